// File: rtl/riff_metadata_chunk_stripper_assert.svh
// ----------------------------------------------------------------------------
// RIFF metadata chunk stripper assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RIFF_METADATA_CHUNK_STRIPPER_ASSERT_SVH
`define RIFF_METADATA_CHUNK_STRIPPER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RMCS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rmcs check failed");

// The consequent must hold in the cycle after the antecedent.
`define RMCS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rmcs check failed");

`endif

// File: rtl/rmcs_pkg.sv
// ----------------------------------------------------------------------------
// RIFF metadata chunk stripper package
// Signatures, chunk names, walker phase codes and the summary record type.
// ----------------------------------------------------------------------------
`default_nettype none

package rmcs_pkg;

	// Four-character codes, first character in the lowest byte.
	localparam logic [31:0] SIG_RIFF  = 32'h4646_4952;
	localparam logic [31:0] SIG_WEBP  = 32'h5042_4557;
	localparam logic [31:0] FCC_EXIF  = 32'h4649_5845;
	localparam logic [31:0] FCC_XMP   = 32'h2050_4D58;
	localparam logic [31:0] FCC_ICCP  = 32'h5043_4349;

	// Rewritten file header with a zero size field, byte 0 in the low bits.
	localparam logic [95:0] FRESH_HDR = {SIG_WEBP, 32'h0000_0000, SIG_RIFF};

	localparam logic [3:0] FILE_HDR_LAST  = 4'd11;
	localparam logic [3:0] CHUNK_HDR_LAST = 4'd7;
	localparam logic [3:0] FILE_HDR_BYTES = 4'd12;
	localparam logic [3:0] CHUNK_HDR_BYTES = 4'd8;

	// Walker phases.
	localparam logic [2:0] PH_HEADER    = 3'd0;
	localparam logic [2:0] PH_CHUNK_HDR = 3'd1;
	localparam logic [2:0] PH_BODY      = 3'd2;
	localparam logic [2:0] PH_STOPPED   = 3'd3;

	typedef struct packed {
		logic        header_valid;
		logic [31:0] riff_size;
		logic [31:0] removed_bytes;
		logic [31:0] removed_chunks;
	} summary_t;

endpackage

`default_nettype wire

// File: rtl/riff_metadata_chunk_stripper.sv
// ----------------------------------------------------------------------------
// RIFF metadata chunk stripper
// Walks a RIFF/WEBP byte stream, drops EXIF, XMP and ICCP chunks, passes the
// rest and closes each file with a summary record.
// ----------------------------------------------------------------------------
//  channel   direction  request
//  s_axis    in         one file byte, tlast on the last byte of a file
//  m_axis    out        one kept byte, or the summary when tuser is high
//  cfg       in         file length in bytes, 32 bits
//
// A byte is registered on entry and processed once the burst register is
// free. That register unloads one result per cycle while m_axis is ready, so
// plain body bytes flow at one per cycle. A completed file header releases 12
// results and a kept chunk header 8; the entry stage stalls while a burst and
// any summary drain. Reset returns the walker to the file header phase and
// the file length to zero. Either side may stall at any time without loss.
// ----------------------------------------------------------------------------
`default_nettype none

`include "riff_metadata_chunk_stripper_assert.svh"

module riff_metadata_chunk_stripper
	import rmcs_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,

	input  wire logic         s_axis_tvalid,
	output      logic         s_axis_tready,
	input  wire logic [7:0]   s_axis_tdata,   // data_byte[7:0]
	input  wire logic         s_axis_tlast,

	output      logic         m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// out_byte[7:0], header_valid[8], riff_size[40:9], removed_bytes[72:41],
	// removed_chunks[104:73], zero fill[111:105]
	output      logic [111:0] m_axis_tdata,
	output      logic         m_axis_tuser,   // is_summary[0]
	output      logic         m_axis_tlast,

	input  wire logic         cfg_valid,
	output      logic         cfg_ready,
	input  wire logic [31:0]  cfg_data
);

	logic [31:0] file_length_q;

	// Entry stage.
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        fin_s1;

	// Walker state.
	logic [2:0]  phase_q;
	logic [3:0]  cnt_q;
	logic        ok_q;
	logic [7:0]  chdr_buf_q [0:6];
	logic [32:0] body_q;
	logic        keep_q;
	logic [32:0] kept_q;
	logic [31:0] rm_bytes_q;
	logic [31:0] rm_chunks_q;

	// Result burst.
	logic [3:0]  brem_q;
	logic [3:0]  bbytes_q;
	logic [95:0] bdata_q;
	summary_t    bsum_q;

	logic        burst_free;
	logic        advance;
	logic        out_take;

	// Next-state values.
	logic [2:0]  phase_nx;
	logic [3:0]  cnt_nx;
	logic        ok_nx;
	logic [32:0] body_nx;
	logic        keep_nx;
	logic [32:0] kept_nx;
	logic [31:0] rm_bytes_nx;
	logic [31:0] rm_chunks_nx;
	logic [3:0]  emit_n;
	logic [95:0] emit_data;
	summary_t    sum_nx;

	logic [63:0] chdr_full;
	logic [31:0] chunk_len;
	logic [32:0] padded;
	logic        is_meta;
	logic [34:0] fit_sum;
	logic [33:0] rm_sum;
	logic [7:0]  sig_byte;

	assign cfg_ready     = 1'b1;
	assign out_take      = m_axis_tvalid && m_axis_tready;
	assign burst_free    = (brem_q == 4'd0) || ((brem_q == 4'd1) && m_axis_tready);
	assign advance       = valid_s1 && burst_free;
	assign s_axis_tready = !valid_s1 || burst_free;

	assign chdr_full = {byte_s1, chdr_buf_q[6], chdr_buf_q[5], chdr_buf_q[4],
		chdr_buf_q[3], chdr_buf_q[2], chdr_buf_q[1], chdr_buf_q[0]};
	assign chunk_len = chdr_full[63:32];
	assign padded    = {1'b0, chunk_len} + {32'd0, chunk_len[0]};
	assign is_meta   = (chdr_full[31:0] == FCC_EXIF) || (chdr_full[31:0] == FCC_XMP)
		|| (chdr_full[31:0] == FCC_ICCP);
	assign fit_sum   = {2'b00, kept_q} + 35'd8 + {2'b00, padded};
	assign rm_sum    = {2'b00, rm_bytes_q} + 34'd8 + {1'b0, padded};
	assign sig_byte  = cnt_q[3] ? SIG_WEBP[{cnt_q[1:0], 3'b000} +: 8]
		: SIG_RIFF[{cnt_q[1:0], 3'b000} +: 8];

	always_comb begin
		phase_nx     = phase_q;
		cnt_nx       = cnt_q;
		ok_nx        = ok_q;
		body_nx      = body_q;
		keep_nx      = keep_q;
		kept_nx      = kept_q;
		rm_bytes_nx  = rm_bytes_q;
		rm_chunks_nx = rm_chunks_q;
		emit_n       = 4'd0;
		emit_data    = {88'd0, byte_s1};

		case (phase_q)
			PH_HEADER: begin
				// Bytes 4 to 7 carry the old size and are not checked.
				if ((cnt_q[3] || !cnt_q[2]) && (byte_s1 != sig_byte)) begin
					ok_nx = 1'b0;
				end
				cnt_nx = cnt_q + 4'd1;
				if (cnt_q == FILE_HDR_LAST) begin
					cnt_nx = 4'd0;
					if (ok_nx) begin
						emit_n    = FILE_HDR_BYTES;
						emit_data = FRESH_HDR;
						kept_nx   = kept_q + 33'(FILE_HDR_BYTES);
						phase_nx  = PH_CHUNK_HDR;
					end else begin
						phase_nx = PH_STOPPED;
					end
				end
			end
			PH_CHUNK_HDR: begin
				cnt_nx = cnt_q + 4'd1;
				if (cnt_q == CHUNK_HDR_LAST) begin
					cnt_nx = 4'd0;
					if (is_meta) begin
						rm_bytes_nx  = (rm_sum[33:32] != 2'b00) ? 32'hFFFF_FFFF : rm_sum[31:0];
						rm_chunks_nx = (rm_chunks_q == 32'hFFFF_FFFF) ? rm_chunks_q
							: rm_chunks_q + 32'd1;
						keep_nx      = 1'b0;
						body_nx      = padded;
						phase_nx     = (padded != 33'd0) ? PH_BODY : PH_CHUNK_HDR;
					end else if (fit_sum > {3'b000, file_length_q}) begin
						phase_nx = PH_STOPPED;
					end else begin
						emit_n    = CHUNK_HDR_BYTES;
						emit_data = {32'd0, chdr_full};
						kept_nx   = kept_q + 33'(CHUNK_HDR_BYTES);
						keep_nx   = 1'b1;
						body_nx   = padded;
						phase_nx  = (padded != 33'd0) ? PH_BODY : PH_CHUNK_HDR;
					end
				end
			end
			PH_BODY: begin
				if (keep_q) begin
					emit_n  = 4'd1;
					kept_nx = kept_q + 33'd1;
				end
				body_nx = body_q - 33'd1;
				if (body_q == 33'd1) begin
					phase_nx = PH_CHUNK_HDR;
				end
			end
			default: begin
			end
		endcase

		sum_nx.header_valid   = (phase_nx != PH_HEADER) && ok_nx;
		sum_nx.riff_size      = sum_nx.header_valid ? (kept_nx[31:0] - 32'd8) : 32'd0;
		sum_nx.removed_bytes  = rm_bytes_nx;
		sum_nx.removed_chunks = rm_chunks_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_length_q <= 32'd0;
		end else if (cfg_valid && cfg_ready) begin
			file_length_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			fin_s1  <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			cnt_q       <= 4'd0;
			ok_q        <= 1'b1;
			body_q      <= 33'd0;
			keep_q      <= 1'b0;
			kept_q      <= 33'd0;
			rm_bytes_q  <= 32'd0;
			rm_chunks_q <= 32'd0;
		end else if (advance) begin
			if (fin_s1) begin
				// End of file: start over for the next file.
				phase_q     <= PH_HEADER;
				cnt_q       <= 4'd0;
				ok_q        <= 1'b1;
				body_q      <= 33'd0;
				keep_q      <= 1'b0;
				kept_q      <= 33'd0;
				rm_bytes_q  <= 32'd0;
				rm_chunks_q <= 32'd0;
			end else begin
				phase_q     <= phase_nx;
				cnt_q       <= cnt_nx;
				ok_q        <= ok_nx;
				body_q      <= body_nx;
				keep_q      <= keep_nx;
				kept_q      <= kept_nx;
				rm_bytes_q  <= rm_bytes_nx;
				rm_chunks_q <= rm_chunks_nx;
			end
		end
	end

	// The eighth header byte is taken straight from the entry stage.
	always_ff @(posedge clk) begin
		if (advance && (phase_q == PH_CHUNK_HDR) && (cnt_q != CHUNK_HDR_LAST)) begin
			chdr_buf_q[cnt_q[2:0]] <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brem_q   <= 4'd0;
			bbytes_q <= 4'd0;
		end else if (advance) begin
			brem_q   <= emit_n + {3'd0, fin_s1};
			bbytes_q <= emit_n;
		end else if (out_take) begin
			brem_q <= brem_q - 4'd1;
			if (bbytes_q != 4'd0) begin
				bbytes_q <= bbytes_q - 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			bdata_q <= emit_data;
			bsum_q  <= sum_nx;
		end else if (out_take && (bbytes_q != 4'd0)) begin
			bdata_q <= {8'd0, bdata_q[95:8]};
		end
	end

	assign m_axis_tvalid = (brem_q != 4'd0);
	assign m_axis_tuser  = (bbytes_q == 4'd0);
	assign m_axis_tlast  = (brem_q == 4'd1);
	assign m_axis_tdata  = m_axis_tuser
		? {7'd0, bsum_q.removed_chunks, bsum_q.removed_bytes, bsum_q.riff_size,
			bsum_q.header_valid, 8'd0}
		: {104'd0, bdata_q[7:0]};

	`RMCS_ASSERT_SAME(a_summary_closes_burst, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
	`RMCS_ASSERT_SAME(a_bytes_within_burst, 1'b1, bbytes_q <= brem_q)
	`RMCS_ASSERT_SAME(a_body_not_empty, phase_q == PH_BODY, body_q != 33'd0)
	`RMCS_ASSERT_NEXT(a_stalled_entry_held, valid_s1 && !burst_free, valid_s1)

endmodule

`default_nettype wire
